>>> hw/rtl/eer_pkg.sv
package eer_pkg;

   localparam int MAX_ITEMS = 256;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int PROD_W    = 2 * CNT_W;
   localparam int NUM_W     = PROD_W + 1;
   localparam int SCORE_W   = 16;
   localparam int FRAC_W    = 16;
   localparam int EER_W     = FRAC_W + 1;
   localparam int QUO_W     = EER_W + 1;
   localparam int DIV_W     = NUM_W + QUO_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam logic [EER_W-1:0] EER_ONE = EER_W'(1) << FRAC_W;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               label;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_CHECK,
      ST_PN,
      ST_SC_RD,
      ST_SC_CMP,
      ST_MUL_TP,
      ST_MUL_FP,
      ST_TEST,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

>>> hw/rtl/eer_store.sv
// Sorted item list: one write port, one registered read port.
module eer_store (
   input  logic                 clock,
   input  eer_pkg::mem_req_type mem_req,
   output eer_pkg::entry_type   rd_data
);

   eer_pkg::entry_type mem_ff [eer_pkg::MAX_ITEMS];
   eer_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/eer_mul.sv
// Shared count multiplier, product registered.
module eer_mul (
   input  logic                        clock,
   input  logic [eer_pkg::CNT_W-1:0]   mul_a,
   input  logic [eer_pkg::CNT_W-1:0]   mul_b,
   output logic [eer_pkg::PROD_W-1:0]  prod
);

   logic [eer_pkg::PROD_W-1:0] prod_ff;
   logic [eer_pkg::PROD_W-1:0] prod_in;

   assign prod_in = eer_pkg::PROD_W'(mul_a) * eer_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/eer_div.sv
// Restoring divider, one quotient bit per cycle.
// quo = round(num * 2^16 / den), ties up, clamped to 1.0.
module eer_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [eer_pkg::NUM_W-1:0]  num,
   input  logic [eer_pkg::NUM_W-1:0]  den,
   output logic                       done,
   output logic [eer_pkg::EER_W-1:0]  quo
);

   logic                        busy_ff;
   logic                        busy_in;
   logic                        done_ff;
   logic                        done_in;
   logic [eer_pkg::STEP_W-1:0]  step_ff;
   logic [eer_pkg::DIV_W-1:0]   rem_ff;
   logic [eer_pkg::DIV_W-1:0]   dsh_ff;
   logic [eer_pkg::QUO_W-1:0]   q_ff;
   logic                        fits;

   assign fits = (rem_ff >= dsh_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && (step_ff == '0)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // dividend num*2^17 + den over divisor 2*den, shifted up by 17
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= eer_pkg::DIV_W'({num, {(eer_pkg::FRAC_W + 1){1'b0}}})
                    + eer_pkg::DIV_W'(den);
         dsh_ff  <= {den, {eer_pkg::QUO_W{1'b0}}};
         step_ff <= eer_pkg::STEP_W'(eer_pkg::DIV_STEPS - 1);
         q_ff    <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         q_ff    <= {q_ff[eer_pkg::QUO_W-2:0], fits};
         dsh_ff  <= dsh_ff >> 1;
         step_ff <= step_ff - eer_pkg::STEP_W'(1);
      end
   end

   assign done = done_ff;
   assign quo  = (q_ff > eer_pkg::QUO_W'(eer_pkg::EER_ONE)) ? eer_pkg::EER_ONE
                                                            : q_ff[eer_pkg::EER_W-1:0];

endmodule

>>> hw/rtl/equal_error_rate_scan.sv
// Insertion walks from the tail with a read and a compare per entry looked at, then the write;
// the first item into an empty list is written at once. After the final item the scan reads
// each entry, and at each group end multiplies tp and fp and runs the stop test; then come the
// divide and the output step. An empty class skips the scan and divide.
// Items are taken one at a time, through the list memory's single read port and the shared
// multiplier. Synchronous active-high reset empties the set and drops any pending result.
module equal_error_rate_scan (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [eer_pkg::SCORE_W-1:0]         req_score,
   input  logic                                req_label,
   input  logic                                req_last_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [eer_pkg::EER_W-1:0]           rsp_eer_value,
   output logic                                rsp_no_class
);

   eer_pkg::state_type              state_ff;
   eer_pkg::state_type              state_in;

   // item being inserted
   logic [eer_pkg::SCORE_W-1:0]     score_ff;
   logic                            label_ff;
   logic                            last_ff;
   logic [eer_pkg::CNT_W-1:0]       idx_ff;

   // set counts
   logic [eer_pkg::CNT_W-1:0]       cnt_ff;
   logic [eer_pkg::CNT_W-1:0]       pos_ff;
   logic [eer_pkg::CNT_W-1:0]       neg_ff;

   // scan state
   logic [eer_pkg::CNT_W-1:0]       k_ff;
   logic [eer_pkg::CNT_W-1:0]       tp_ff;
   logic [eer_pkg::CNT_W-1:0]       fp_ff;
   logic [eer_pkg::SCORE_W-1:0]     grp_ff;
   logic [eer_pkg::PROD_W-1:0]      pn_ff;
   logic [eer_pkg::PROD_W-1:0]      tpn_ff;

   // result and output register
   logic [eer_pkg::EER_W-1:0]       res_eer_ff;
   logic                            res_nc_ff;
   logic                            rsp_valid_ff;
   logic [eer_pkg::EER_W-1:0]       rsp_eer_ff;
   logic                            rsp_nc_ff;

   eer_pkg::mem_req_type            mem_req;
   eer_pkg::entry_type              rd_data;
   logic [eer_pkg::CNT_W-1:0]       mul_a;
   logic [eer_pkg::CNT_W-1:0]       mul_b;
   logic [eer_pkg::PROD_W-1:0]      prod;
   logic                            div_start;
   logic                            div_done;
   logic [eer_pkg::EER_W-1:0]       div_quo;

   logic                            req_take;
   logic                            full;
   logic                            empty_class;
   logic                            move_up;
   logic [eer_pkg::CNT_W-1:0]       idx_dec;
   logic [eer_pkg::CNT_W-1:0]       k_inc;
   logic                            boundary;
   logic [eer_pkg::NUM_W-1:0]       test_sum;
   logic                            stop;
   logic [eer_pkg::NUM_W-1:0]       num;
   logic [eer_pkg::NUM_W-1:0]       den;
   logic                            out_free;

   // -------------------------------------------------------------------------
   // Units
   // -------------------------------------------------------------------------
   eer_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   eer_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   eer_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // -------------------------------------------------------------------------
   // Shared conditions
   // -------------------------------------------------------------------------
   assign req_stall   = (state_ff != eer_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign full        = (cnt_ff == eer_pkg::CNT_W'(eer_pkg::MAX_ITEMS));
   assign empty_class = (pos_ff == '0) || (neg_ff == '0);

   // insertion walks from the tail; equal scores stay ahead of the new item
   assign move_up  = (rd_data.score < score_ff);
   assign idx_dec  = idx_ff - eer_pkg::CNT_W'(1);

   // a group ends where the score changes
   assign k_inc    = k_ff + eer_pkg::CNT_W'(1);
   assign boundary = (k_ff != '0) && (rd_data.score != grp_ff);

   // stop test tp*N + fp*P >= P*N; prod holds fp*P in ST_TEST
   assign test_sum = eer_pkg::NUM_W'(tpn_ff) + eer_pkg::NUM_W'(prod);
   assign stop     = (test_sum >= eer_pkg::NUM_W'(pn_ff)) || (k_ff == cnt_ff);

   // (P - tp)*N + fp*P = P*N - tp*N + fp*P, over 2*P*N
   assign num = eer_pkg::NUM_W'(pn_ff) - eer_pkg::NUM_W'(tpn_ff) + eer_pkg::NUM_W'(prod);
   assign den = {pn_ff, 1'b0};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // -------------------------------------------------------------------------
   // Sequencer: next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eer_pkg::ST_IDLE: begin
            if (req_take) begin
               priority if (full) begin
                  state_in = req_last_item ? eer_pkg::ST_CHECK : eer_pkg::ST_IDLE;
               end else if (cnt_ff == '0) begin
                  state_in = eer_pkg::ST_INS_PUT;
               end else begin
                  state_in = eer_pkg::ST_INS_RD;
               end
            end
         end
         eer_pkg::ST_INS_RD: begin
            state_in = eer_pkg::ST_INS_CMP;
         end
         eer_pkg::ST_INS_CMP: begin
            if (move_up && (idx_dec != '0)) begin
               state_in = eer_pkg::ST_INS_RD;
            end else begin
               state_in = eer_pkg::ST_INS_PUT;
            end
         end
         eer_pkg::ST_INS_PUT: begin
            state_in = last_ff ? eer_pkg::ST_CHECK : eer_pkg::ST_IDLE;
         end
         eer_pkg::ST_CHECK: begin
            state_in = empty_class ? eer_pkg::ST_OUT : eer_pkg::ST_PN;
         end
         eer_pkg::ST_PN: begin
            state_in = eer_pkg::ST_SC_RD;
         end
         eer_pkg::ST_SC_RD: begin
            state_in = eer_pkg::ST_SC_CMP;
         end
         eer_pkg::ST_SC_CMP: begin
            if (boundary || (k_inc == cnt_ff)) begin
               state_in = eer_pkg::ST_MUL_TP;
            end else begin
               state_in = eer_pkg::ST_SC_RD;
            end
         end
         eer_pkg::ST_MUL_TP: begin
            state_in = eer_pkg::ST_MUL_FP;
         end
         eer_pkg::ST_MUL_FP: begin
            state_in = eer_pkg::ST_TEST;
         end
         eer_pkg::ST_TEST: begin
            state_in = stop ? eer_pkg::ST_DIV : eer_pkg::ST_SC_CMP;
         end
         eer_pkg::ST_DIV: begin
            state_in = div_done ? eer_pkg::ST_OUT : eer_pkg::ST_DIV;
         end
         eer_pkg::ST_OUT: begin
            state_in = out_free ? eer_pkg::ST_IDLE : eer_pkg::ST_OUT;
         end
         default: begin
            state_in = eer_pkg::ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Sequencer: unit controls
   // -------------------------------------------------------------------------
   always_comb begin
      mem_req   = '0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      unique case (state_ff)
         eer_pkg::ST_INS_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = idx_dec[eer_pkg::ADDR_W-1:0];
         end
         eer_pkg::ST_INS_CMP: begin
            mem_req.wr_en   = move_up;
            mem_req.wr_addr = idx_ff[eer_pkg::ADDR_W-1:0];
            mem_req.wr_data = rd_data;
         end
         eer_pkg::ST_INS_PUT: begin
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = idx_ff[eer_pkg::ADDR_W-1:0];
            mem_req.wr_data.score = score_ff;
            mem_req.wr_data.label = label_ff;
         end
         eer_pkg::ST_CHECK: begin
            mul_a = pos_ff;
            mul_b = neg_ff;
         end
         eer_pkg::ST_SC_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = k_ff[eer_pkg::ADDR_W-1:0];
         end
         eer_pkg::ST_MUL_TP: begin
            mul_a = tp_ff;
            mul_b = neg_ff;
         end
         eer_pkg::ST_MUL_FP: begin
            mul_a = fp_ff;
            mul_b = pos_ff;
         end
         eer_pkg::ST_TEST: begin
            div_start = stop;
         end
         default: begin
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Control registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eer_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         neg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == eer_pkg::ST_INS_PUT) begin
            cnt_ff <= cnt_ff + eer_pkg::CNT_W'(1);
            if (label_ff) begin
               pos_ff <= pos_ff + eer_pkg::CNT_W'(1);
            end else begin
               neg_ff <= neg_ff + eer_pkg::CNT_W'(1);
            end
         end
         // result handed over: set emptied for the next one
         if ((state_ff == eer_pkg::ST_OUT) && out_free) begin
            cnt_ff       <= '0;
            pos_ff       <= '0;
            neg_ff       <= '0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Datapath registers
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         score_ff <= req_score;
         label_ff <= req_label;
         last_ff  <= req_last_item;
         idx_ff   <= cnt_ff;
      end
      if ((state_ff == eer_pkg::ST_INS_CMP) && move_up) begin
         idx_ff <= idx_dec;
      end
      if (state_ff == eer_pkg::ST_CHECK) begin
         k_ff       <= '0;
         tp_ff      <= '0;
         fp_ff      <= '0;
         res_eer_ff <= '0;
         res_nc_ff  <= empty_class;
      end
      if (state_ff == eer_pkg::ST_PN) begin
         pn_ff <= prod;
      end
      // consume one entry into the running group
      if ((state_ff == eer_pkg::ST_SC_CMP) && !boundary) begin
         k_ff   <= k_inc;
         grp_ff <= rd_data.score;
         if (rd_data.label) begin
            tp_ff <= tp_ff + eer_pkg::CNT_W'(1);
         end else begin
            fp_ff <= fp_ff + eer_pkg::CNT_W'(1);
         end
      end
      if (state_ff == eer_pkg::ST_MUL_FP) begin
         tpn_ff <= prod;
      end
      // test failed at a group edge: open the next group with the held entry
      if ((state_ff == eer_pkg::ST_TEST) && !stop) begin
         grp_ff <= rd_data.score;
      end
      if ((state_ff == eer_pkg::ST_DIV) && div_done) begin
         res_eer_ff <= div_quo;
         res_nc_ff  <= 1'b0;
      end
      if ((state_ff == eer_pkg::ST_OUT) && out_free) begin
         rsp_eer_ff <= res_eer_ff;
         rsp_nc_ff  <= res_nc_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_eer_value = rsp_eer_ff;
   assign rsp_no_class  = rsp_nc_ff;

`ifndef SYNTHESIS
   // class counts always add up to the stored item count
   a_counts_sum: assert property (@(posedge clock) disable iff (reset)
      (eer_pkg::CNT_W'(pos_ff + neg_ff) == cnt_ff))
      else $error("class counts do not match item count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= eer_pkg::CNT_W'(eer_pkg::MAX_ITEMS)))
      else $error("item count beyond capacity");

   a_no_class_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_class) |-> (rsp_eer_value == '0))
      else $error("no_class result carries a non-zero rate");

   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == eer_pkg::ST_DIV))
      else $error("divider finished outside the divide step");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == eer_pkg::ST_SC_RD) |-> (k_ff < cnt_ff))
      else $error("scan read beyond stored items");
`endif

endmodule
